// ===== sv/qvu_pkg.sv =====
// Shared constants, types and helper functions of the tabular Q-value update core.
package qvu_pkg;

	localparam int FEATURE_SLOTS = 128;
	localparam int GRID_CELLS = 256;
	localparam int VALUE_BITS = 24;
	localparam int FRAC_BITS = 16;
	localparam int MOVES = 4;
	localparam int TABLE_DEPTH = FEATURE_SLOTS * GRID_CELLS * MOVES;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(MOVES + 1);

	localparam int FEAT_W = 7;
	localparam int CELL_W = 8;
	localparam int MOVE_W = 2;
	localparam int OUT_W = 24;
	localparam int COEF_W = 16;
	localparam int REWARD_W = 18;
	localparam int ADD_W = VALUE_BITS + 8;
	localparam int MRES_W = VALUE_BITS + 2;
	localparam int PROD_W = VALUE_BITS + COEF_W + 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DISCOUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_COST = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PROGRESS_REWARD = 2'd3;

	localparam logic [COEF_W-1:0] LEARNING_RATE_RST = 16'd19661;
	localparam logic [COEF_W-1:0] DISCOUNT_RST = 16'd64225;
	localparam logic [COEF_W-1:0] STEP_COST_RST = 16'd655;
	localparam logic [REWARD_W-1:0] PROGRESS_REWARD_RST = 18'd65536;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [VALUE_BITS:0] diff_t;
	typedef logic signed [MRES_W-1:0] mres_t;
	typedef logic signed [ADD_W-1:0] sum_t;
	typedef logic signed [OUT_W-1:0] out_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [REWARD_W-1:0] reward_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		coef_t learning_rate;
		coef_t discount;
		coef_t step_cost;
		reward_t progress_reward;
	} cfg_t;

	typedef struct packed {
		logic mul_en;
		diff_t mul_a;
		coef_t mul_c;
		sum_t add_a;
		sum_t add_b;
	} alu_req_t;

	typedef struct packed {
		mres_t mul_res;
		sum_t sum;
		value_t clamped;
		logic sat;
	} alu_rsp_t;

	function automatic logic in_range(logic [FEAT_W-1:0] f, logic [CELL_W-1:0] s);
		return (int'(f) < FEATURE_SLOTS) && (int'(s) < GRID_CELLS);
	endfunction

	function automatic addr_t table_addr(logic [FEAT_W-1:0] f, logic [CELL_W-1:0] s,
			logic [MOVE_W-1:0] a);
		return addr_t'((int'(f) * GRID_CELLS + int'(s)) * MOVES + int'(a));
	endfunction

endpackage

// ===== sv/qvu_if.sv =====
// Request and result channel interfaces of the tabular Q-value update core.
interface qvu_in_if
	import qvu_pkg::*;
();
	logic valid;
	logic ready;
	logic [FEAT_W-1:0] feature;
	logic [CELL_W-1:0] cell_req;
	logic [MOVE_W-1:0] move;
	logic [FEAT_W-1:0] next_feature;
	logic next_known;
	logic [CELL_W-1:0] next_cell;
	logic progress;
	logic finished;

	modport source (output valid, feature, cell_req, move, next_feature, next_known,
		next_cell, progress, finished, input ready);
	modport sink (input valid, feature, cell_req, move, next_feature, next_known,
		next_cell, progress, finished, output ready);
endinterface

interface qvu_out_if
	import qvu_pkg::*;
();
	logic valid;
	logic ready;
	out_t new_value;
	out_t next_best;
	logic saturated;

	modport source (output valid, new_value, next_best, saturated, input ready);
	modport sink (input valid, new_value, next_best, saturated, output ready);
endinterface

// ===== sv/qvu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qvu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/qvu_cfg.sv =====
// APB configuration registers of the tabular Q-value update core.
module qvu_cfg
	import qvu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);
	cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate <= LEARNING_RATE_RST;
			cfg_q.discount <= DISCOUNT_RST;
			cfg_q.step_cost <= STEP_COST_RST;
			cfg_q.progress_reward <= PROGRESS_REWARD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LEARNING_RATE: cfg_q.learning_rate <= pwdata[COEF_W-1:0];
				REG_DISCOUNT: cfg_q.discount <= pwdata[COEF_W-1:0];
				REG_STEP_COST: cfg_q.step_cost <= pwdata[COEF_W-1:0];
				REG_PROGRESS_REWARD: cfg_q.progress_reward <= pwdata[REWARD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LEARNING_RATE: prdata = PDATA_W'(cfg_q.learning_rate);
			REG_DISCOUNT: prdata = PDATA_W'(cfg_q.discount);
			REG_STEP_COST: prdata = PDATA_W'(cfg_q.step_cost);
			REG_PROGRESS_REWARD: prdata = PDATA_W'(cfg_q.progress_reward);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/qvu_alu.sv =====
// Shared arithmetic unit: registered fractional multiplier and saturating adder.
module qvu_alu
	import qvu_pkg::*;
(
	input  logic clk,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	logic signed [PROD_W-1:0] prod;
	mres_t mul_res_q;
	sum_t sum;

	// The product drops its fraction bits, which floors toward minus infinity.
	assign prod = req.mul_a * $signed({1'b0, req.mul_c});

	always_ff @(posedge clk) begin
		if (req.mul_en) begin
			mul_res_q <= prod[PROD_W-1:FRAC_BITS];
		end
	end

	assign sum = req.add_a + req.add_b;

	always_comb begin
		rsp.mul_res = mul_res_q;
		rsp.sum = sum;
		rsp.sat = 1'b0;
		rsp.clamped = value_t'(sum);
		if (sum > sum_t'(VALUE_MAX)) begin
			rsp.clamped = VALUE_MAX;
			rsp.sat = 1'b1;
		end else if (sum < sum_t'(VALUE_MIN)) begin
			rsp.clamped = VALUE_MIN;
			rsp.sat = 1'b1;
		end
	end
endmodule

// ===== sv/tabular_q_value_update_core.sv =====
// Top level of the tabular Q-value update core: sequencer, value table and output register.
// After reset the core sweeps the whole value table to zero, one entry per cycle;
// sample.ready stays low during the sweep while configuration writes are taken.
// Each accepted sample then goes through five table reads (the four next-state entries and the
// current entry) through the single RAM read port, then a discount multiply, a target add,
// an error subtract, a learning-rate multiply and a final add with write-back, all on one
// shared multiplier and one shared adder. The result sits in an output register, so the
// next sample is accepted while an earlier result is still waiting.
module tabular_q_value_update_core
	import qvu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	qvu_in_if.sink sample,
	qvu_out_if.source result
);
	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_READ = 8'b0000_0100,
		S_MULG = 8'b0000_1000,
		S_TGT = 8'b0001_0000,
		S_DIFF = 8'b0010_0000,
		S_MULA = 8'b0100_0000,
		S_NEW = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	addr_t clr_addr_q;
	logic out_valid_q;

	logic [FEAT_W-1:0] f_q;
	logic [CELL_W-1:0] s_q;
	logic [MOVE_W-1:0] a_q;
	logic [FEAT_W-1:0] nf_q;
	logic [CELL_W-1:0] ns_q;
	logic known_q;
	logic prog_q;
	logic fin_q;

	value_t best_q;
	value_t cur_q;
	sum_t base_q;
	value_t tgt_q;
	diff_t diff_q;
	logic sat_q;

	out_t new_value_q;
	out_t next_best_q;
	logic saturated_q;

	cfg_t cfg;
	alu_req_t req;
	alu_rsp_t rsp;

	logic we;
	addr_t waddr;
	value_t wdata;
	addr_t raddr;
	value_t rdata;
	value_t nval;
	logic out_free;
	addr_t cur_addr;

	qvu_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	qvu_alu u_alu (
		.clk(clk),
		.req(req),
		.rsp(rsp)
	);

	qvu_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free = !out_valid_q || result.ready;
	assign cur_addr = table_addr(f_q, s_q, a_q);
	assign nval = (known_q && in_range(nf_q, ns_q)) ? rdata : '0;
	assign sample.ready = (state_q == S_IDLE);

	always_comb begin
		raddr = table_addr(nf_q, ns_q, cnt_q[MOVE_W-1:0]);
		if (cnt_q == CNT_W'(MOVES)) begin
			raddr = cur_addr;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = cur_addr;
		wdata = rsp.clamped;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (state_q == S_NEW && out_free && in_range(f_q, s_q)) begin
			we = 1'b1;
		end
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_MULG: begin
				req.mul_en = 1'b1;
				req.mul_a = diff_t'(best_q);
				req.mul_c = cfg.discount;
				req.add_a = prog_q ? sum_t'({1'b0, cfg.progress_reward}) : '0;
				req.add_b = -sum_t'({1'b0, cfg.step_cost});
			end
			S_TGT: begin
				req.add_a = base_q;
				req.add_b = fin_q ? '0 : sum_t'(rsp.mul_res);
			end
			S_DIFF: begin
				req.add_a = sum_t'(tgt_q);
				req.add_b = -sum_t'(cur_q);
			end
			S_MULA: begin
				req.mul_en = 1'b1;
				req.mul_a = diff_q;
				req.mul_c = cfg.learning_rate;
			end
			S_NEW: begin
				req.add_a = sum_t'(cur_q);
				req.add_b = sum_t'(rsp.mul_res);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + addr_t'(1);
					if (clr_addr_q == addr_t'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (sample.valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOVES)) begin
						state_q <= S_MULG;
					end
				end
				S_MULG: state_q <= S_TGT;
				S_TGT: state_q <= S_DIFF;
				S_DIFF: state_q <= S_MULA;
				S_MULA: state_q <= S_NEW;
				S_NEW: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_NEW && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && sample.valid) begin
			f_q <= sample.feature;
			s_q <= sample.cell_req;
			a_q <= sample.move;
			nf_q <= sample.next_feature;
			ns_q <= sample.next_cell;
			known_q <= sample.next_known;
			prog_q <= sample.progress;
			fin_q <= sample.finished;
		end
		if (state_q == S_READ && cnt_q != '0) begin
			if (cnt_q == CNT_W'(1) || nval > best_q) begin
				best_q <= nval;
			end
		end
		if (state_q == S_MULG) begin
			cur_q <= in_range(f_q, s_q) ? rdata : '0;
			base_q <= rsp.sum;
		end
		if (state_q == S_TGT) begin
			tgt_q <= rsp.clamped;
			sat_q <= rsp.sat;
		end
		if (state_q == S_DIFF) begin
			diff_q <= diff_t'(rsp.sum);
		end
		if (state_q == S_NEW && out_free) begin
			new_value_q <= out_t'(rsp.clamped);
			next_best_q <= out_t'(best_q);
			saturated_q <= sat_q | rsp.sat;
		end
	end

	assign result.valid = out_valid_q;
	assign result.new_value = new_value_q;
	assign result.next_best = next_best_q;
	assign result.saturated = saturated_q;
endmodule
